[hdl/snsc_pkg.sv]
`default_nettype none
package snsc_pkg;
    localparam int MaxRows = 16;
    localparam int MaxCols = 16;
    localparam int MaxDims = 16;
    localparam int Neurons = MaxRows * MaxCols;
    localparam int NW = $clog2(Neurons);
    localparam int DW = $clog2(MaxDims);
    localparam int DimLimit = (MaxDims < 16) ? MaxDims : 16;
    localparam int AccW = 37;
    localparam int DistW = 18;
    localparam int ScoreW = 21;

    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_LABEL   = 2'd1;
    localparam logic [1:0] KIND_PATTERN = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_DIMS = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  neuron_index;
        logic [3:0]  component_index;
        logic signed [15:0] value;
        logic [15:0] class_label;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] label;
        logic [7:0]  winner_index;
        logic [20:0] best_score;
    } t_out_beat;

    typedef struct packed {
        logic          dist_start;
        logic          dist_clear;
        logic          dist_store;
        logic          score_start;
        logic [NW-1:0] neuron;
        logic [DW-1:0] dim;
        logic [2:0]    nb;
        logic          emit;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
    } t_status;
endpackage
`default_nettype wire

[hdl/som_neighbour_sum_classifier_top.sv]
`default_nettype none
// One beat per cycle while busy is low. Weight, label and short pattern beats
// finish at once; the beat carrying the last component holds busy high while
// distances and neighbour sums are computed for every neuron, mostly waiting on
// the single root unit, which takes the neurons one at a time; then o_valid pulses for one cycle.
// The receiver cannot stall.
module som_neighbour_sum_classifier_top
    import snsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in_beat    i_data,
    output logic             o_valid,
    output t_out_beat        o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [4:0]  i_cfg_data
);
    logic [4:0] r_rows, r_cols, r_dims;
    logic [4:0] rows, cols, dims;
    logic       acc, go, ctrl_busy, done;
    t_cmd       cmd;
    t_status    st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 5'd1; r_cols <= 5'd1; r_dims <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS: r_rows <= i_cfg_data;
                REG_COLS: r_cols <= i_cfg_data;
                REG_DIMS: r_dims <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows = (r_rows == 0) ? 5'd1 : (r_rows > 5'(MaxRows) ? 5'(MaxRows) : r_rows);
    assign cols = (r_cols == 0) ? 5'd1 : (r_cols > 5'(MaxCols) ? 5'(MaxCols) : r_cols);
    assign dims = (r_dims == 0) ? 5'd1 : (r_dims > 5'(DimLimit) ? 5'(DimLimit) : r_dims);

    assign acc = start && !busy;
    assign go = acc && i_data.kind == KIND_PATTERN
        && {1'b0, i_data.component_index} == dims - 1'b1;
    assign busy = ctrl_busy;
    assign o_valid = done;

    snsc_ctrl u_ctrl (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_go (go),
        .i_rows (rows), .i_cols (cols), .i_dims (dims),
        .i_status (st), .o_cmd (cmd), .o_busy (ctrl_busy), .o_done (done)
    );

    snsc_datapath u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_wr (acc), .i_beat (i_data),
        .i_cmd (cmd), .o_status (st), .o_result (o_data)
    );
endmodule
`default_nettype wire

[hdl/snsc_isqrt.sv]
`default_nettype none
module snsc_isqrt
    import snsc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [AccW-1:0]  i_value,
    output logic                  o_done,
    output logic [DistW-1:0]      o_root
);
    localparam int RootW = (AccW + 1) / 2;
    localparam int CntW = $clog2(RootW + 1);

    logic [AccW+1:0]   r_rem;
    logic [RootW-1:0]  r_root;
    logic [2*RootW-1:0] r_val;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [AccW+1:0]   n_trial;
    logic [AccW+1:0]   n_rem2;

    always_comb begin
        n_rem2 = {r_rem[AccW-1:0], r_val[2*RootW-1 -: 2]};
        n_trial = n_rem2 - {{(AccW+2-RootW-2){1'b0}}, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(RootW);
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= (2*RootW)'(i_value);
            end else if (r_busy) begin
                r_val <= {r_val[2*RootW-3:0], 2'b00};
                if (!n_trial[AccW+1]) begin
                    r_rem  <= n_trial;
                    r_root <= {r_root[RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem2;
                    r_root <= {r_root[RootW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[DistW-1:0];
endmodule
`default_nettype wire

[hdl/snsc_datapath.sv]
`default_nettype none
module snsc_datapath
    import snsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire t_in_beat    i_beat,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output t_out_beat        o_result
);
    logic signed [15:0] r_weight [Neurons*MaxDims];
    logic [15:0]        r_label_mem [Neurons];
    logic signed [15:0] r_pattern [MaxDims];
    logic [DistW-1:0]   r_dist [Neurons];

    logic signed [15:0] r_w;
    logic signed [15:0] r_p;
    logic               r_mul_v;
    logic signed [16:0] r_diff;
    logic               r_diff_v;
    logic [33:0]        r_sq;
    logic               r_sq_v;
    logic [AccW-1:0]    r_acc;
    logic [DistW-1:0]   r_dist_rd;
    logic [ScoreW-1:0]  r_score;
    logic [ScoreW-1:0]  r_best;
    logic [NW-1:0]      r_win;
    logic [15:0]        r_label_rd;
    logic               r_nb_v;
    logic               r_have;
    logic [NW-1:0]      r_cur;
    logic               sqrt_done;
    logic [DistW-1:0]   sqrt_root;

    always_ff @(posedge i_clk) begin
        if (i_wr && i_beat.kind == KIND_WEIGHT && i_beat.component_index < 5'(MaxDims)
            && i_beat.neuron_index < 9'(Neurons))
            r_weight[{i_beat.neuron_index[NW-1:0], i_beat.component_index[DW-1:0]}]
                <= i_beat.value;
        if (i_wr && i_beat.kind == KIND_LABEL && i_beat.neuron_index < 9'(Neurons))
            r_label_mem[i_beat.neuron_index[NW-1:0]] <= i_beat.class_label;
        if (i_wr && i_beat.kind == KIND_PATTERN && i_beat.component_index < 5'(MaxDims))
            r_pattern[i_beat.component_index[DW-1:0]] <= i_beat.value;
        r_w <= r_weight[{i_cmd.neuron, i_cmd.dim}];
        r_p <= r_pattern[i_cmd.dim];
        r_diff <= 17'(r_w) - 17'(r_p);
        r_sq <= $unsigned(34'(r_diff) * 34'(r_diff));
        if (i_cmd.dist_clear)
            r_acc <= '0;
        else if (r_sq_v)
            r_acc <= r_acc + AccW'(r_sq);
        if (sqrt_done)
            r_dist[i_cmd.neuron] <= sqrt_root;
        r_dist_rd <= r_dist[i_cmd.neuron];
        r_label_rd <= r_label_mem[r_win];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_diff_v <= 1'b0;
            r_sq_v <= 1'b0;
            r_nb_v <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_mul_v <= i_cmd.dist_start;
            r_diff_v <= r_mul_v;
            r_sq_v <= r_diff_v;
            r_nb_v <= i_cmd.nb != 3'd0;
            if (i_cmd.score_start) begin
                r_score <= '0;
                r_cur <= i_cmd.neuron;
            end else if (r_nb_v) begin
                r_score <= r_score + ScoreW'(r_dist_rd);
            end
            if (i_cmd.dist_clear && i_cmd.neuron == '0 && !i_cmd.score_start)
                r_have <= 1'b0;
            if (i_cmd.score_start && i_cmd.nb == 3'd0 && r_cur != i_cmd.neuron) begin
                if (!r_have || r_score < r_best) begin
                    r_have <= 1'b1;
                    r_best <= r_score;
                    r_win <= r_cur;
                end
            end
            if (i_cmd.dist_store && i_cmd.nb == 3'd0 && !r_nb_v
                && (!r_have || r_score < r_best)) begin
                r_have <= 1'b1;
                r_best <= r_score;
                r_win <= r_cur;
            end
        end
    end

    snsc_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dist_store && r_nb_v == 1'b0 && i_cmd.score_start == 1'b0
                  && i_cmd.emit == 1'b0 && i_cmd.nb == 3'd7),
        .i_value (r_acc),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_status.sqrt_done = sqrt_done;
    assign o_result.label = r_label_rd;
    assign o_result.winner_index = 8'(r_win);
    assign o_result.best_score = r_best;
endmodule
`default_nettype wire

[hdl/snsc_ctrl.sv]
`default_nettype none
module snsc_ctrl
    import snsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [4:0]  i_rows,
    input  wire logic [4:0]  i_cols,
    input  wire logic [4:0]  i_dims,
    input  wire t_status     i_status,
    output t_cmd             o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DIST  = 8'b00000010,
        S_DRAIN = 8'b00000100,
        S_SQRT  = 8'b00001000,
        S_NB    = 8'b00010000,
        S_NBW   = 8'b00100000,
        S_CMP   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    logic [DW-1:0] r_d;
    logic [2:0]    r_k;
    logic [NW:0]   r_n;
    logic [4:0]    r_y, r_x;
    logic [2:0]    r_nb;
    logic [1:0]    r_w;
    logic [3:0]    r_out;
    logic [NW:0]   total;
    logic [NW:0]   nb_idx;
    logic          nb_ok;

    assign total = (NW+1)'(i_rows) * (NW+1)'(i_cols);

    always_comb begin
        nb_ok = 1'b0;
        nb_idx = r_n;
        case (r_nb)
            3'd1: begin nb_ok = 1'b1; nb_idx = r_n; end
            3'd2: begin nb_ok = r_y != 0; nb_idx = r_n - (NW+1)'(i_cols); end
            3'd3: begin nb_ok = r_y + 1 < i_rows; nb_idx = r_n + (NW+1)'(i_cols); end
            3'd4: begin nb_ok = r_x != 0; nb_idx = r_n - 1'b1; end
            3'd5: begin nb_ok = r_x + 1 < i_cols; nb_idx = r_n + 1'b1; end
            default: begin nb_ok = 1'b0; nb_idx = r_n; end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.neuron = r_n[NW-1:0];
        o_cmd.dim = r_d;
        case (r_state)
            S_DIST: o_cmd.dist_start = 1'b1;
            S_DRAIN: if (r_k == 3'd4) begin o_cmd.dist_store = 1'b1; o_cmd.nb = 3'd7; end
            S_NB: begin
                o_cmd.neuron = nb_idx[NW-1:0];
                if (r_nb == 3'd1) o_cmd.score_start = 1'b1;
                else if (nb_ok) o_cmd.nb = 3'd1;
            end
            S_CMP: o_cmd.dist_store = 1'b1;
            S_OUT: o_cmd.emit = 1'b1;
            default: ;
        endcase
        if (r_state == S_NB && r_nb == 3'd1) o_cmd.nb = 3'd1;
        if (r_state == S_DIST && r_d == '0) o_cmd.dist_clear = r_k == 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_go) begin
                    r_state <= S_DIST; r_n <= '0; r_d <= '0; r_k <= '0;
                end
                S_DIST: begin
                    r_k <= 3'd1;
                    if (r_d == DW'(i_dims - 1'b1)) begin
                        r_state <= S_DRAIN; r_k <= 3'd0;
                    end else r_d <= r_d + 1'b1;
                end
                S_DRAIN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 3'd4) r_state <= S_SQRT;
                end
                S_SQRT: if (i_status.sqrt_done) begin
                    if (r_n + 1'b1 == total) begin
                        r_state <= S_NB; r_n <= '0; r_y <= '0; r_x <= '0; r_nb <= 3'd1;
                    end else begin
                        r_n <= r_n + 1'b1; r_d <= '0; r_k <= '0; r_state <= S_DIST;
                    end
                end
                S_NB: begin
                    if (r_nb == 3'd5) begin r_state <= S_NBW; r_w <= '0; end
                    r_nb <= r_nb + 1'b1;
                end
                S_NBW: begin
                    r_w <= r_w + 1'b1;
                    if (r_w == 2'd1) r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_n + 1'b1 == total) begin
                        r_state <= S_OUT; r_out <= '0;
                    end else begin
                        r_n <= r_n + 1'b1; r_nb <= 3'd1; r_state <= S_NB;
                        if (r_x + 1 == i_cols) begin r_x <= '0; r_y <= r_y + 1'b1; end
                        else r_x <= r_x + 1'b1;
                    end
                end
                S_OUT: begin
                    r_out <= r_out + 1'b1;
                    if (r_out == 4'd2) begin o_done <= 1'b1; r_state <= S_IDLE; end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = r_state != S_IDLE;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_go_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_state == S_IDLE) |=> r_state == S_DIST) else $error("start lost");
endmodule
`default_nettype wire
